[src/sbt_pkg.sv]
// ---------------------------------------------------------------------------
// sbt_pkg: shared types and helpers for the S-expression byte tokenizer
// Token kinds, lexer modes, the result item layout and character classes.
// ---------------------------------------------------------------------------
package sbt_pkg;

    typedef enum logic [3:0] {
        K_LPAREN  = 4'd0,
        K_RPAREN  = 4'd1,
        K_QUOTE   = 4'd2,
        K_DOT     = 4'd3,
        K_BOOL    = 4'd4,
        K_INT     = 4'd5,
        K_STRCHAR = 4'd6,
        K_STREND  = 4'd7,
        K_SYMCHAR = 4'd8,
        K_SYMEND  = 4'd9,
        K_EOF     = 4'd10,
        K_UNTERM  = 4'd11,
        K_BADCHAR = 4'd12
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_COMMENT = 4'd1,
        M_DOT     = 4'd2,
        M_HASH    = 4'd3,
        M_MINUS   = 4'd4,
        M_STR     = 4'd5,
        M_STR_ESC = 4'd6,
        M_INT     = 4'd7,
        M_SYM     = 4'd8,
        M_FAILED  = 4'd9
    } mode_t;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned TDATA_W     = 80;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] accum;
        logic        minus;
    } lex_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] int_value;
        logic        bool_value;
        logic [7:0]  char_value;
        logic        last;
    } out_item_t;

    // What a byte does when it arrives between tokens.
    typedef struct packed {
        mode_t      mode;
        logic       start_int;
        logic       emit;
        kind_t      kind;
        logic [7:0] ch;
    } idle_act_t;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_sym(logic [7:0] b);
        logic r;
        r = is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
        r = r || (b == 8'h2D) || (b == 8'h5F) || (b == 8'h21) || (b == 8'h3F)
              || (b == 8'h2B) || (b == 8'h2A) || (b == 8'h2F) || (b == 8'h3C)
              || (b == 8'h3E) || (b == 8'h3D) || (b == 8'h3A);
        return r;
    endfunction

    function automatic out_item_t make_item(kind_t kind, logic [7:0] ch);
        out_item_t it;
        it.kind       = kind;
        it.int_value  = 64'd0;
        it.bool_value = 1'b0;
        it.char_value = ch;
        it.last       = 1'b0;
        return it;
    endfunction

    function automatic idle_act_t idle_action(logic [7:0] b);
        idle_act_t a;
        a.mode      = M_IDLE;
        a.start_int = 1'b0;
        a.emit      = 1'b0;
        a.kind      = K_BADCHAR;
        a.ch        = 8'd0;
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_COMMA) begin
            a.mode = M_IDLE;
        end else if (b == CH_SEMI) begin
            a.mode = M_COMMENT;
        end else if (b == CH_LPAREN) begin
            a.emit = 1'b1;
            a.kind = K_LPAREN;
        end else if (b == CH_RPAREN) begin
            a.emit = 1'b1;
            a.kind = K_RPAREN;
        end else if (b == CH_SQUOTE) begin
            a.emit = 1'b1;
            a.kind = K_QUOTE;
        end else if (b == CH_DOT) begin
            a.mode = M_DOT;
        end else if (b == CH_HASH) begin
            a.mode = M_HASH;
        end else if (b == CH_DQUOTE) begin
            a.mode = M_STR;
        end else if (is_digit(b)) begin
            a.mode      = M_INT;
            a.start_int = 1'b1;
        end else if (b == CH_MINUS) begin
            a.mode = M_MINUS;
        end else if (is_sym(b)) begin
            a.mode = M_SYM;
            a.emit = 1'b1;
            a.kind = K_SYMCHAR;
            a.ch   = b;
        end else begin
            a.mode = M_FAILED;
            a.emit = 1'b1;
            a.kind = K_BADCHAR;
        end
        return a;
    endfunction

endpackage

[src/sbt_lex_step.sv]
// ---------------------------------------------------------------------------
// sbt_lex_step: one tokenizer step
// Given the lexer state and one input item, form the next state and up to
// three result items in order, with the count of valid ones.
// ---------------------------------------------------------------------------
module sbt_lex_step (
    input  sbt_pkg::lex_state_t            state_cur,
    input  logic [7:0]                     data_byte,
    input  logic                           source_end,
    output sbt_pkg::lex_state_t            state_nxt,
    output sbt_pkg::out_item_t [2:0]       results,
    output logic [1:0]                     result_count
);

    sbt_pkg::idle_act_t ia;
    logic [63:0]        int_signed;
    logic [63:0]        accum_x10;
    logic [63:0]        digit_val;
    logic [1:0]         idle_slot;
    logic               do_idle;

    assign digit_val = {60'd0, data_byte[3:0] - sbt_pkg::CH_ZERO[3:0]};
    assign int_signed = state_cur.minus ? (64'd0 - state_cur.accum) : state_cur.accum;
    assign accum_x10 = {state_cur.accum[60:0], 3'b000} + {state_cur.accum[62:0], 1'b0}
                     + digit_val;

    always_comb begin
        ia           = sbt_pkg::idle_action(data_byte);
        state_nxt    = state_cur;
        results[0]   = sbt_pkg::make_item(sbt_pkg::K_EOF, 8'd0);
        results[1]   = sbt_pkg::make_item(sbt_pkg::K_EOF, 8'd0);
        results[2]   = sbt_pkg::make_item(sbt_pkg::K_EOF, 8'd0);
        result_count = 2'd0;
        idle_slot    = 2'd0;
        do_idle      = 1'b0;

        if (source_end) begin
            // finish the pending token, then always close with eof
            case (state_cur.mode)
                sbt_pkg::M_DOT, sbt_pkg::M_HASH: begin
                    results[0]   = sbt_pkg::make_item(sbt_pkg::K_BADCHAR, 8'd0);
                    result_count = 2'd2;
                end
                sbt_pkg::M_MINUS: begin
                    results[0]   = sbt_pkg::make_item(sbt_pkg::K_SYMCHAR, sbt_pkg::CH_MINUS);
                    results[1]   = sbt_pkg::make_item(sbt_pkg::K_SYMEND, 8'd0);
                    result_count = 2'd3;
                end
                sbt_pkg::M_STR, sbt_pkg::M_STR_ESC: begin
                    results[0]   = sbt_pkg::make_item(sbt_pkg::K_UNTERM, 8'd0);
                    result_count = 2'd2;
                end
                sbt_pkg::M_INT: begin
                    results[0]           = sbt_pkg::make_item(sbt_pkg::K_INT, 8'd0);
                    results[0].int_value = int_signed;
                    result_count         = 2'd2;
                end
                sbt_pkg::M_SYM: begin
                    results[0]   = sbt_pkg::make_item(sbt_pkg::K_SYMEND, 8'd0);
                    result_count = 2'd2;
                end
                default: begin
                    result_count = 2'd1;
                end
            endcase
            state_nxt.mode  = sbt_pkg::M_IDLE;
            state_nxt.accum = 64'd0;
            state_nxt.minus = 1'b0;
        end else begin
            case (state_cur.mode)
                sbt_pkg::M_COMMENT: begin
                    if (data_byte == sbt_pkg::CH_LF) begin
                        state_nxt.mode = sbt_pkg::M_IDLE;
                    end
                end
                sbt_pkg::M_DOT: begin
                    if (sbt_pkg::is_sym(data_byte)) begin
                        results[0]     = sbt_pkg::make_item(sbt_pkg::K_BADCHAR, 8'd0);
                        result_count   = 2'd1;
                        state_nxt.mode = sbt_pkg::M_FAILED;
                    end else begin
                        results[0]   = sbt_pkg::make_item(sbt_pkg::K_DOT, 8'd0);
                        result_count = 2'd1;
                        do_idle      = 1'b1;
                        idle_slot    = 2'd1;
                    end
                end
                sbt_pkg::M_HASH: begin
                    if (data_byte == sbt_pkg::CH_LC_T || data_byte == sbt_pkg::CH_LC_F) begin
                        results[0]            = sbt_pkg::make_item(sbt_pkg::K_BOOL, 8'd0);
                        results[0].bool_value = (data_byte == sbt_pkg::CH_LC_T);
                        state_nxt.mode        = sbt_pkg::M_IDLE;
                    end else begin
                        results[0]     = sbt_pkg::make_item(sbt_pkg::K_BADCHAR, 8'd0);
                        state_nxt.mode = sbt_pkg::M_FAILED;
                    end
                    result_count = 2'd1;
                end
                sbt_pkg::M_MINUS: begin
                    if (sbt_pkg::is_digit(data_byte)) begin
                        state_nxt.accum = digit_val;
                        state_nxt.minus = 1'b1;
                        state_nxt.mode  = sbt_pkg::M_INT;
                    end else if (sbt_pkg::is_sym(data_byte)) begin
                        results[0]     = sbt_pkg::make_item(sbt_pkg::K_SYMCHAR, sbt_pkg::CH_MINUS);
                        results[1]     = sbt_pkg::make_item(sbt_pkg::K_SYMCHAR, data_byte);
                        result_count   = 2'd2;
                        state_nxt.mode = sbt_pkg::M_SYM;
                    end else begin
                        results[0]   = sbt_pkg::make_item(sbt_pkg::K_SYMCHAR, sbt_pkg::CH_MINUS);
                        results[1]   = sbt_pkg::make_item(sbt_pkg::K_SYMEND, 8'd0);
                        result_count = 2'd2;
                        do_idle      = 1'b1;
                        idle_slot    = 2'd2;
                    end
                end
                sbt_pkg::M_STR: begin
                    if (data_byte == sbt_pkg::CH_DQUOTE) begin
                        results[0]     = sbt_pkg::make_item(sbt_pkg::K_STREND, 8'd0);
                        result_count   = 2'd1;
                        state_nxt.mode = sbt_pkg::M_IDLE;
                    end else if (data_byte == sbt_pkg::CH_BSLASH) begin
                        state_nxt.mode = sbt_pkg::M_STR_ESC;
                    end else begin
                        results[0]   = sbt_pkg::make_item(sbt_pkg::K_STRCHAR, data_byte);
                        result_count = 2'd1;
                    end
                end
                sbt_pkg::M_STR_ESC: begin
                    if (data_byte == sbt_pkg::CH_LC_N) begin
                        results[0] = sbt_pkg::make_item(sbt_pkg::K_STRCHAR, sbt_pkg::CH_LF);
                    end else if (data_byte == sbt_pkg::CH_LC_T) begin
                        results[0] = sbt_pkg::make_item(sbt_pkg::K_STRCHAR, sbt_pkg::CH_TAB);
                    end else if (data_byte == sbt_pkg::CH_LC_R) begin
                        results[0] = sbt_pkg::make_item(sbt_pkg::K_STRCHAR, sbt_pkg::CH_CR);
                    end else begin
                        results[0] = sbt_pkg::make_item(sbt_pkg::K_STRCHAR, data_byte);
                    end
                    result_count   = 2'd1;
                    state_nxt.mode = sbt_pkg::M_STR;
                end
                sbt_pkg::M_INT: begin
                    if (sbt_pkg::is_digit(data_byte)) begin
                        state_nxt.accum = accum_x10;
                    end else begin
                        results[0]           = sbt_pkg::make_item(sbt_pkg::K_INT, 8'd0);
                        results[0].int_value = int_signed;
                        result_count         = 2'd1;
                        state_nxt.accum      = 64'd0;
                        state_nxt.minus      = 1'b0;
                        do_idle              = 1'b1;
                        idle_slot            = 2'd1;
                    end
                end
                sbt_pkg::M_SYM: begin
                    if (sbt_pkg::is_sym(data_byte)) begin
                        results[0]   = sbt_pkg::make_item(sbt_pkg::K_SYMCHAR, data_byte);
                        result_count = 2'd1;
                    end else begin
                        results[0]   = sbt_pkg::make_item(sbt_pkg::K_SYMEND, 8'd0);
                        result_count = 2'd1;
                        do_idle      = 1'b1;
                        idle_slot    = 2'd1;
                    end
                end
                sbt_pkg::M_FAILED: begin
                    state_nxt.mode = sbt_pkg::M_FAILED;
                end
                default: begin
                    do_idle   = 1'b1;
                    idle_slot = 2'd0;
                end
            endcase

            // handle the byte as if it arrived between tokens
            if (do_idle) begin
                state_nxt.mode = ia.mode;
                if (ia.start_int) begin
                    state_nxt.accum = digit_val;
                    state_nxt.minus = 1'b0;
                end
                if (ia.emit) begin
                    results[idle_slot] = sbt_pkg::make_item(ia.kind, ia.ch);
                    result_count       = idle_slot + 2'd1;
                end
            end
        end

        results[0].last = (result_count == 2'd1);
        results[1].last = (result_count == 2'd2);
        results[2].last = (result_count == 2'd3);
    end

endmodule

[src/sexpr_byte_tokenizer.sv]
// ---------------------------------------------------------------------------
// sexpr_byte_tokenizer: streaming S-expression tokenizer
// Path: an accepted item passes the input register, then the result register,
//   before its first result shows on m_*, and waits while results are queued.
// Throughput: one item per cycle while each item gives at most one result and
//   m_tready stays high; an item that gives several results holds the result
//   register until all of them are taken.
// Reset: aresetn low clears the lexer to idle with a zero accumulator and
//   empties the input and result registers.
// ---------------------------------------------------------------------------
module sexpr_byte_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // source_end: closes the source, no byte carried

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sbt_pkg::TDATA_W-1:0] m_tdata, // [63:0] int_value, [64] bool_value,
                                   // [72:65] char_value, [79:73] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last result caused by one input item
);

    // Input register: holds one accepted item until the step logic takes it.
    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic [7:0]                     in_byte_reg;
    logic                           in_end_reg;

    // Lexer state.
    sbt_pkg::lex_state_t            state_reg;
    sbt_pkg::lex_state_t            state_next;

    // Result register: up to three items, slot 0 drives the m_* ports.
    sbt_pkg::out_item_t [2:0]       slot_reg;
    sbt_pkg::out_item_t [2:0]       slot_next;
    logic [1:0]                     cnt_reg;
    logic [1:0]                     cnt_next;

    sbt_pkg::out_item_t [2:0]       step_results;
    logic [1:0]                     step_count;

    logic                           drain;
    logic [1:0]                     cnt_after;
    logic                           consume;
    logic                           load;

    sbt_lex_step u_step (
        .state_cur    (state_reg),
        .data_byte    (in_byte_reg),
        .source_end   (in_end_reg),
        .state_nxt    (state_next),
        .results      (step_results),
        .result_count (step_count)
    );

    // Drain one result per handshake. A held item advances when it gives no
    // result or when the result register will be empty by this edge.
    assign drain     = (cnt_reg != 2'd0) && m_tready;
    assign cnt_after = cnt_reg - {1'b0, drain};
    assign consume   = in_valid_reg && ((step_count == 2'd0) || (cnt_after == 2'd0));
    assign load      = consume && (step_count != 2'd0);

    assign s_tready  = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            slot_next = step_results;
            cnt_next  = step_count;
        end else if (drain) begin
            // advance the queued results toward the output
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            cnt_reg         <= 2'd0;
            state_reg.mode  <= sbt_pkg::M_IDLE;
            state_reg.accum <= 64'd0;
            state_reg.minus <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (consume) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        slot_reg <= slot_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {7'd0, slot_reg[0].char_value, slot_reg[0].bool_value,
                       slot_reg[0].int_value};
    assign m_tuser  = slot_reg[0].kind;
    assign m_tlast  = slot_reg[0].last;

    // The newest queued result always closes its item.
    a_tail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd0) |-> slot_reg[cnt_reg - 2'd1].last)
        else $error("queued results do not end with a last marker");

    // An end-of-source item leaves the lexer idle with a cleared accumulator.
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_end_reg) |=> (state_reg.mode == sbt_pkg::M_IDLE &&
                                     state_reg.accum == 64'd0 && !state_reg.minus))
        else $error("lexer state not cleared after end of source");

    // The failed mode is left only through an end-of-source item.
    a_failed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && !in_end_reg && state_reg.mode == sbt_pkg::M_FAILED)
        |=> (state_reg.mode == sbt_pkg::M_FAILED))
        else $error("failed mode left on a data byte");

    // A pending minus sign only exists while an integer is being read.
    a_minus_in_int: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.minus |-> (state_reg.mode == sbt_pkg::M_INT))
        else $error("minus flag set outside an integer");

    // New results are never loaded over results still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd0 && !m_tready) |=> (cnt_reg == $past(cnt_reg)))
        else $error("result register changed while stalled");

endmodule

[bench/sexpr_byte_tokenizer_test.sv]
// ---------------------------------------------------------------------------
// sexpr_byte_tokenizer_test: self-checking bench for the S-expression tokenizer
// Feeds source bytes and end markers over the input stream. A scoreboard holds
// its own lexer state and predicts the tokens of every accepted item. Each
// returned token is matched field by field against the oldest prediction.
// Idle and stall rates on both sides change from phase to phase.
// ---------------------------------------------------------------------------
module sexpr_byte_tokenizer_test;

    // Predicts the token stream from accepted source items and checks what
    // the block returns against it.
    class lexer_scoreboard;
        sbt_pkg::mode_t     lx_mode;
        logic [63:0]        magnitude;
        bit                 negative;
        sbt_pkg::out_item_t expected_tokens[$];
        sbt_pkg::out_item_t step_tokens[$];
        int                 mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            lx_mode   = sbt_pkg::M_IDLE;
            magnitude = '0;
            negative  = 1'b0;
        endfunction

        static function bit is_numeral(logic [7:0] b);
            return (b >= "0") && (b <= "9");
        endfunction

        static function bit is_name_char(logic [7:0] b);
            string extra;
            extra = "-_!?+*/<>=:";
            if (is_numeral(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
                return 1'b1;
            foreach (extra[i])
                if (extra[i] == b)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void put_token(sbt_pkg::kind_t k, logic [63:0] iv = '0, logic bv = 1'b0,
                                logic [7:0] cv = '0);
            sbt_pkg::out_item_t t;
            if (step_tokens.size() >= sbt_pkg::MAX_RESULTS)
                return;
            t.kind       = k;
            t.int_value  = iv;
            t.bool_value = bv;
            t.char_value = cv;
            t.last       = 1'b0;
            step_tokens.push_back(t);
        endfunction

        // Emit the pending integer; negation wraps just like the magnitude.
        function void close_integer();
            put_token(sbt_pkg::K_INT, negative ? -magnitude : magnitude);
            magnitude = '0;
            negative  = 1'b0;
        endfunction

        function void trip(sbt_pkg::kind_t k);
            put_token(k);
            lx_mode = sbt_pkg::M_FAILED;
        endfunction

        function void between_tokens(logic [7:0] b);
            lx_mode = sbt_pkg::M_IDLE;
            case (b)
                " ", "\t", "\n", "\r", ",": ;
                ";":  lx_mode = sbt_pkg::M_COMMENT;
                "(":  put_token(sbt_pkg::K_LPAREN);
                ")":  put_token(sbt_pkg::K_RPAREN);
                "'":  put_token(sbt_pkg::K_QUOTE);
                ".":  lx_mode = sbt_pkg::M_DOT;
                "#":  lx_mode = sbt_pkg::M_HASH;
                "\"": lx_mode = sbt_pkg::M_STR;
                "-":  lx_mode = sbt_pkg::M_MINUS;
                default: begin
                    if (is_numeral(b)) begin
                        magnitude = 64'(b - "0");
                        negative  = 1'b0;
                        lx_mode   = sbt_pkg::M_INT;
                    end else if (is_name_char(b)) begin
                        put_token(sbt_pkg::K_SYMCHAR, '0, 1'b0, b);
                        lx_mode = sbt_pkg::M_SYM;
                    end else begin
                        trip(sbt_pkg::K_BADCHAR);
                    end
                end
            endcase
        endfunction

        // End marker: finish whatever token is open, then eof and a fresh start.
        function void close_source();
            case (lx_mode)
                sbt_pkg::M_DOT, sbt_pkg::M_HASH: put_token(sbt_pkg::K_BADCHAR);
                sbt_pkg::M_MINUS: begin
                    put_token(sbt_pkg::K_SYMCHAR, '0, 1'b0, "-");
                    put_token(sbt_pkg::K_SYMEND);
                end
                sbt_pkg::M_STR, sbt_pkg::M_STR_ESC: put_token(sbt_pkg::K_UNTERM);
                sbt_pkg::M_INT: close_integer();
                sbt_pkg::M_SYM: put_token(sbt_pkg::K_SYMEND);
                default: ;
            endcase
            put_token(sbt_pkg::K_EOF);
            clear_state();
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] ch;
            case (lx_mode)
                sbt_pkg::M_COMMENT: begin
                    if (b == "\n")
                        lx_mode = sbt_pkg::M_IDLE;
                end
                sbt_pkg::M_DOT: begin
                    if (is_name_char(b)) begin
                        trip(sbt_pkg::K_BADCHAR);
                    end else begin
                        put_token(sbt_pkg::K_DOT);
                        between_tokens(b);
                    end
                end
                sbt_pkg::M_HASH: begin
                    if (b == "t") begin
                        put_token(sbt_pkg::K_BOOL, '0, 1'b1);
                        lx_mode = sbt_pkg::M_IDLE;
                    end else if (b == "f") begin
                        put_token(sbt_pkg::K_BOOL);
                        lx_mode = sbt_pkg::M_IDLE;
                    end else begin
                        trip(sbt_pkg::K_BADCHAR);
                    end
                end
                sbt_pkg::M_MINUS: begin
                    if (is_numeral(b)) begin
                        magnitude = 64'(b - "0");
                        negative  = 1'b1;
                        lx_mode   = sbt_pkg::M_INT;
                    end else if (is_name_char(b)) begin
                        put_token(sbt_pkg::K_SYMCHAR, '0, 1'b0, "-");
                        put_token(sbt_pkg::K_SYMCHAR, '0, 1'b0, b);
                        lx_mode = sbt_pkg::M_SYM;
                    end else begin
                        put_token(sbt_pkg::K_SYMCHAR, '0, 1'b0, "-");
                        put_token(sbt_pkg::K_SYMEND);
                        between_tokens(b);
                    end
                end
                sbt_pkg::M_STR: begin
                    if (b == "\"") begin
                        put_token(sbt_pkg::K_STREND);
                        lx_mode = sbt_pkg::M_IDLE;
                    end else if (b == "\\") begin
                        lx_mode = sbt_pkg::M_STR_ESC;
                    end else begin
                        put_token(sbt_pkg::K_STRCHAR, '0, 1'b0, b);
                    end
                end
                sbt_pkg::M_STR_ESC: begin
                    ch = (b == "n") ? "\n" : (b == "t") ? "\t" : (b == "r") ? "\r" : b;
                    put_token(sbt_pkg::K_STRCHAR, '0, 1'b0, ch);
                    lx_mode = sbt_pkg::M_STR;
                end
                sbt_pkg::M_INT: begin
                    if (is_numeral(b)) begin
                        magnitude = magnitude * 64'd10 + 64'(b - "0");
                    end else begin
                        close_integer();
                        between_tokens(b);
                    end
                end
                sbt_pkg::M_SYM: begin
                    if (is_name_char(b)) begin
                        put_token(sbt_pkg::K_SYMCHAR, '0, 1'b0, b);
                    end else begin
                        put_token(sbt_pkg::K_SYMEND);
                        between_tokens(b);
                    end
                end
                sbt_pkg::M_FAILED: ;
                default: between_tokens(b);
            endcase
        endfunction

        // Note one accepted input item. Returns 0 when the block ignores it.
        function bit note_item(logic [7:0] b, logic src_end);
            bit live;
            live = src_end || (lx_mode != sbt_pkg::M_FAILED);
            step_tokens.delete();
            if (src_end)
                close_source();
            else
                take_byte(b);
            if (step_tokens.size() != 0)
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
            return live;
        endfunction

        function void check_token(logic [3:0] kind, logic [79:0] data, logic last);
            sbt_pkg::out_item_t want;
            if (expected_tokens.size() == 0) begin
                $error("token_kind %0d arrived with no token expected", kind);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            if (kind !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (data[63:0] !== want.int_value) begin
                $error("int_value: expected %0d, got %0d",
                       $signed(want.int_value), $signed(data[63:0]));
                mismatches++;
            end
            if (data[64] !== want.bool_value) begin
                $error("bool_value: expected %0d, got %0d", want.bool_value, data[64]);
                mismatches++;
            end
            if (data[72:65] !== want.char_value) begin
                $error("char_value: expected 0x%02h, got 0x%02h",
                       want.char_value, data[72:65]);
                mismatches++;
            end
            if (data[79:73] !== 7'd0) begin
                $error("tdata padding: expected 0, got 0x%02h", data[79:73]);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    localparam int QUIET_LIMIT     = 2000; // cycles with no handshake at all
    localparam int HOLD_CYCLES     = 80;   // long receiver hold-off
    localparam int ITEMS_PER_PHASE = 30;
    localparam int PHASES          = 4;

    // Per phase: no idling, sender idle, receiver stalling, both.
    localparam int TX_IDLE_BY_PHASE [PHASES] = '{0, 75, 0, 38};
    localparam int RX_STALL_BY_PHASE[PHASES] = '{0, 0, 75, 38};

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    lexer_scoreboard sb = new();

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int live_items    = 0;
    int quiet_cycles  = 0;
    bit hold_start    = 1'b0;
    bit rx_hold       = 1'b0;

    // Character pools for the random sources.
    string gap_chars = " \t\n\r,";
    string name_head = "abqxyzAMZ_!?+*/<>=:";
    string name_tail = "abqxyzAMZ_!?+*/<>=:0123456789-";
    string esc_chars = "ntr\\\"q";

    sexpr_byte_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: check every accepted token, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_token(m_tuser, m_tdata, m_tlast);
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    // items, so the block fills up and drops s_tready.
    initial begin
        wait (hold_start);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog: give up once nothing has moved on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sexpr_byte_tokenizer_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Offer one item, with an optional random gap first, and hold it until
    // the block takes it. tvalid stays high on return unless a gap follows.
    task automatic send_item(logic [7:0] b, logic src_end);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= src_end;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_item(b, src_end))
            live_items++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_item(s[i], 1'b0);
    endtask

    // One random source: a few mostly well-formed tokens with random content,
    // separators, a little noise, then the end marker.
    task automatic random_source();
        int         n_tokens;
        int         n_digits;
        logic [7:0] ch;
        n_tokens = $urandom_range(1, 6);
        repeat (n_tokens) begin
            case ($urandom_range(0, 13))
                0: send_item("(", 1'b0);
                1: send_item(")", 1'b0);
                2: send_item("'", 1'b0);
                3: begin
                    // Dot followed by a byte that ends it.
                    send_item(".", 1'b0);
                    send_item(pick_char(" ()"), 1'b0);
                end
                4: begin
                    send_item("#", 1'b0);
                    send_item($urandom_range(0, 1) ? "t" : "f", 1'b0);
                end
                5, 6: begin
                    if ($urandom_range(0, 3) == 0)
                        send_item("-", 1'b0);
                    // Mostly short numbers; now and then a long one that can wrap.
                    n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 25)
                                                          : $urandom_range(1, 4);
                    repeat (n_digits)
                        send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
                7, 8: begin
                    send_item("\"", 1'b0);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_item("\\", 1'b0);
                            send_item(pick_char(esc_chars), 1'b0);
                        end else begin
                            do ch = 8'($urandom_range(1, 255));
                            while (ch == "\"" || ch == "\\");
                            send_item(ch, 1'b0);
                        end
                    end
                    // Leave a string open now and then.
                    if ($urandom_range(0, 9) != 0)
                        send_item("\"", 1'b0);
                end
                9, 10: begin
                    send_item(pick_char(name_head), 1'b0);
                    repeat ($urandom_range(0, 4))
                        send_item(pick_char(name_tail), 1'b0);
                end
                11: begin
                    // Minus that starts a symbol, or stands alone.
                    send_item("-", 1'b0);
                    if ($urandom_range(0, 1))
                        send_item(pick_char(name_head), 1'b0);
                end
                12: begin
                    send_item(";", 1'b0);
                    repeat ($urandom_range(0, 4)) begin
                        do ch = 8'($urandom_range(0, 255)); while (ch == "\n");
                        send_item(ch, 1'b0);
                    end
                    send_item("\n", 1'b0);
                end
                default: begin
                    // Broken input: bad hash, dot glued to a name, any byte.
                    case ($urandom_range(0, 2))
                        0: begin
                            send_item("#", 1'b0);
                            send_item(8'($urandom_range(0, 255)), 1'b0);
                        end
                        1: begin
                            send_item(".", 1'b0);
                            send_item(pick_char(name_tail), 1'b0);
                        end
                        default: send_item(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
            endcase
            if ($urandom_range(0, 9) < 7)
                send_item(pick_char(gap_chars), 1'b0);
        end
        if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        // The byte under the end marker is ignored; randomize it anyway.
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int phase;
        int target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            tx_idle_pct  = TX_IDLE_BY_PHASE[phase];
            rx_stall_pct = RX_STALL_BY_PHASE[phase];

            if (phase == 0) begin
                // Every punctuation token, #t, negative integer, dot before a
                // space, an escaped plain byte, then end of source.
                send_text("'(#t -5 . \"\\q\")");
                send_item(8'h00, 1'b1);
                // NUL between tokens is illegal; later bytes are ignored.
                send_item(8'h00, 1'b0);
                send_item(8'hFF, 1'b0);
                send_item(8'hFF, 1'b1);
                // Lone minus at end of source, then an open string.
                send_item("-", 1'b0);
                send_item(8'h00, 1'b1);
                send_item("\"", 1'b0);
                send_item(8'h00, 1'b1);
                hold_start <= 1'b1;
            end

            target = live_items + ITEMS_PER_PHASE;
            while (live_items < target)
                random_source();

            // Pause the sender until every predicted token is back.
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (sb.pending() != 0);
        end

        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected tokens never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("sexpr_byte_tokenizer_test passed");
        else
            $display("sexpr_byte_tokenizer_test failed");
        $finish;
    end

endmodule
